>>> design/ppcs_pkg.sv
// Shared constants for the PWM pulse capture sequencer: item kinds, phase
// codes, field widths and register reset values. No dependencies.
`default_nettype none

package ppcs_pkg;

  localparam int unsigned KindW    = 2;
  localparam int unsigned WidthW   = 32;
  localparam int unsigned NsW      = 20;
  localparam int unsigned MsW      = 8;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned PeriodW  = 53;
  localparam int unsigned DutyW    = 52;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 120;

  localparam logic [KindW-1:0] KIND_START = 2'd0;
  localparam logic [KindW-1:0] KIND_EDGE  = 2'd1;
  localparam logic [KindW-1:0] KIND_TICK  = 2'd2;
  localparam logic [KindW-1:0] KIND_STOP  = 2'd3;

  localparam logic [PhaseW-1:0] PH_IDLE  = 3'd0;
  localparam logic [PhaseW-1:0] PH_JUNK1 = 3'd1;
  localparam logic [PhaseW-1:0] PH_JUNK2 = 3'd2;
  localparam logic [PhaseW-1:0] PH_DATA  = 3'd3;
  localparam logic [PhaseW-1:0] PH_DONE  = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_NS_PER_TICK = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT_MS  = 1'd1;

  localparam logic [NsW-1:0] RST_NS_PER_TICK = 20'd2666;
  localparam logic [MsW-1:0] RST_TIMEOUT_MS  = 8'd50;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_TIMEOUT = 1'b1;

endpackage

`default_nettype wire

>>> design/pwm_pulse_capture_sequencer.sv
// PWM pulse capture sequencer: state update at accept, then an operand
// register and a product register for period and duty. Depends on ppcs_pkg.
// The result transaction of a tick is registered in the operand register and then the product register.
// Throughput: 1 item per cycle while the output is not stalled; the two multiplies sit in their own stage.
// Reset: phase idle, widths and ms count zero, ns_per_tick 2666, timeout 50,
// pipeline empty.
`default_nettype none

module pwm_pulse_capture_sequencer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] level_was_high, [32:1] width_count, rest zero
  input  wire logic [ppcs_pkg::InDataW-1:0]  s_axis_tdata,
  // [1:0] kind
  input  wire logic [ppcs_pkg::KindW-1:0]    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [52:0] period, [104:53] duty_ns, [112:105] elapsed_ms, rest zero
  output logic [ppcs_pkg::OutDataW-1:0]      m_axis_tdata,
  // [0] status
  output logic [0:0]                         m_axis_tuser,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ppcs_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  wire logic [ppcs_pkg::CfgDataW-1:0] cfg_data_i
);
  import ppcs_pkg::*;

  logic [NsW-1:0]    ns_per_tick_q;
  logic [MsW-1:0]    timeout_q;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [WidthW-1:0] high_q, high_d, low_q, low_d;
  logic [MsW-1:0]    ms_q, ms_d;

  logic              s1_valid_q;
  logic              s1_status_q;
  logic [NsW-1:0]    s1_ns_q;
  logic [WidthW-1:0] s1_high_q;
  logic [WidthW:0]   s1_sum_q;
  logic [MsW-1:0]    s1_ms_q;

  logic              out_valid_q;
  logic              out_status_q;
  logic [PeriodW-1:0] out_period_q;
  logic [DutyW-1:0]  out_duty_q;
  logic [MsW-1:0]    out_ms_q;

  logic              accept;
  logic              out_load;
  logic              s1_load;
  logic              emit;
  logic              emit_status;
  logic [MsW-1:0]    ms_inc;
  logic              lvl_hi;
  logic [WidthW-1:0] width_in;

  assign lvl_hi   = s_axis_tdata[0];
  assign width_in = s_axis_tdata[WidthW:1];

  assign out_load      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || out_load;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign ms_inc        = ms_q + MsW'(1);

  always_comb begin
    phase_d     = phase_q;
    high_d      = high_q;
    low_d       = low_q;
    ms_d        = ms_q;
    emit        = 1'b0;
    emit_status = STATUS_DONE;
    case (s_axis_tuser)
      KIND_START: begin
        high_d  = '0;
        low_d   = '0;
        ms_d    = '0;
        phase_d = PH_JUNK1;
      end
      KIND_EDGE: begin
        if (phase_q != PH_DONE) begin
          if (lvl_hi) begin
            high_d = width_in;
          end else begin
            low_d = width_in;
          end
        end
        case (phase_q)
          PH_JUNK1: phase_d = PH_JUNK2;
          PH_JUNK2: begin
            high_d  = '0;
            low_d   = '0;
            phase_d = PH_DATA;
          end
          PH_DATA: begin
            if (high_d != '0 && low_d != '0) begin
              phase_d = PH_DONE;
            end
          end
          default: ;
        endcase
      end
      KIND_TICK: begin
        if (phase_q != PH_IDLE) begin
          ms_d = ms_inc;
          if (phase_q == PH_DONE && high_q != '0 && low_q != '0) begin
            emit    = 1'b1;
            phase_d = PH_IDLE;
          end else if (ms_inc >= timeout_q) begin
            emit        = 1'b1;
            emit_status = STATUS_TIMEOUT;
            phase_d     = PH_IDLE;
          end
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  assign s1_load = accept || (s1_valid_q && out_load);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ns_per_tick_q <= RST_NS_PER_TICK;
      timeout_q     <= RST_TIMEOUT_MS;
      phase_q       <= PH_IDLE;
      high_q        <= '0;
      low_q         <= '0;
      ms_q          <= '0;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_addr_i)
          REG_NS_PER_TICK: ns_per_tick_q <= cfg_data_i[NsW-1:0];
          REG_TIMEOUT_MS:  timeout_q     <= cfg_data_i[MsW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        phase_q <= phase_d;
        high_q  <= high_d;
        low_q   <= low_d;
        ms_q    <= ms_d;
      end
      if (s1_load) begin
        s1_valid_q <= accept && emit;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // operand stage; a timeout zeroes the ns operand so both products are zero
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      s1_status_q <= emit_status;
      s1_ms_q     <= ms_inc;
      s1_ns_q     <= (emit_status == STATUS_TIMEOUT) ? '0 : ns_per_tick_q;
      s1_high_q   <= high_q;
      s1_sum_q    <= {1'b0, high_q} + {1'b0, low_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      out_status_q <= s1_status_q;
      out_ms_q     <= s1_ms_q;
      out_period_q <= PeriodW'(s1_ns_q) * PeriodW'(s1_sum_q);
      out_duty_q   <= DutyW'(s1_ns_q) * DutyW'(s1_high_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {(OutDataW - PeriodW - DutyW - MsW)'(0),
                          out_ms_q, out_duty_q, out_period_q};

endmodule

`default_nettype wire
